// ===== rtl/lru_open_handle_tracker_macros.svh =====
// Assertion macros shared by the tracker RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef LRU_OPEN_HANDLE_TRACKER_MACROS_SVH
`define LRU_OPEN_HANDLE_TRACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define LRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lrt_pkg.sv =====
// Types and constants of the LRU open-handle tracker.
// No dependencies; imported by every tracker module.
package lrt_pkg;

  localparam int unsigned HANDLE_W   = 6;
  localparam int unsigned MAX_OPEN_W = 7;
  localparam int unsigned COUNT_W    = 7;

  localparam logic [MAX_OPEN_W-1:0] MAX_OPEN_RESET = 7'd32;

  localparam logic FUNC_USE   = 1'b0;
  localparam logic FUNC_CLOSE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_VICT,
    ST_PUSH,
    ST_MARK,
    ST_FIN
  } state_e;

  // memory access strobes from the sequencer
  typedef struct packed {
    logic rd;     // read both arrays at the read address
    logic a_we;   // write newer link / listed flag
    logic a_inl;  // listed flag written with the newer link
    logic b_we;   // write older link
  } mem_ctl_t;

  // result beat, laid out as on the output tdata (lowest field last)
  typedef struct packed {
    logic [COUNT_W-1:0]  open_count;
    logic                was_open;
    logic [HANDLE_W-1:0] evicted_handle;
    logic                evicted_valid;
  } res_t;

endpackage

// ===== rtl/lrt_link_mem.sv =====
// Link storage: newer link plus listed flag in one array, older link in another.
// Uses lrt_pkg; sweeps the listed flags clear after reset.
module lrt_link_mem import lrt_pkg::*; #(
  parameter int unsigned HANDLES = 64
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  mem_ctl_t                                ctl_i,
  input  logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] raddr_i,
  input  logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] a_waddr_i,
  input  logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] a_wnwr_i,
  input  logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] b_waddr_i,
  input  logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] b_wdata_i,
  output logic                                    rd_inl_o,
  output logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] rd_nwr_o,
  output logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] rd_old_o,
  output logic                                    busy_o
);

  localparam int unsigned HW = (HANDLES > 1) ? $clog2(HANDLES) : 1;
  localparam logic [HW-1:0] LAST = HW'(HANDLES - 1);

  logic [HW:0]   mem_a [HANDLES];  // {listed, newer link}
  logic [HW-1:0] mem_b [HANDLES];  // older link

  logic          clr_q, clr_d;
  logic [HW-1:0] clr_cnt_q, clr_cnt_d;
  logic [HW:0]   rd_a_q;
  logic [HW-1:0] rd_b_q;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == LAST) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_a[clr_cnt_q] <= '0;
    end else if (ctl_i.a_we) begin
      mem_a[a_waddr_i] <= {ctl_i.a_inl, a_wnwr_i};
    end
    if (ctl_i.b_we) begin
      mem_b[b_waddr_i] <= b_wdata_i;
    end
    if (ctl_i.rd) begin
      rd_a_q <= mem_a[raddr_i];
      rd_b_q <= mem_b[raddr_i];
    end
  end

  assign rd_inl_o = rd_a_q[HW];
  assign rd_nwr_o = rd_a_q[HW-1:0];
  assign rd_old_o = rd_b_q;
  assign busy_o   = clr_q;

endmodule

// ===== rtl/lrt_ctrl.sv =====
// Request sequencer: list head/tail, count, cap register and result register.
// Uses lrt_pkg and the assertion macros; drives lrt_link_mem.
`include "lru_open_handle_tracker_macros.svh"
module lrt_ctrl import lrt_pkg::*; #(
  parameter int unsigned HANDLES = 64
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [MAX_OPEN_W-1:0]                   cfg_wdata_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    in_func_i,
  input  logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] in_idx_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output res_t                                    out_res_o,
  output mem_ctl_t                                mctl_o,
  output logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] raddr_o,
  output logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] a_waddr_o,
  output logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] a_wnwr_o,
  output logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] b_waddr_o,
  output logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] b_wdata_o,
  input  logic                                    rd_inl_i,
  input  logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] rd_nwr_i,
  input  logic [(HANDLES > 1 ? $clog2(HANDLES) : 1)-1:0] rd_old_i,
  input  logic                                    busy_i
);

  localparam int unsigned HW   = (HANDLES > 1) ? $clog2(HANDLES) : 1;
  localparam int unsigned CW   = $clog2(HANDLES + 1);
  localparam int unsigned CMPW = (CW > MAX_OPEN_W) ? CW : MAX_OPEN_W;
  localparam int unsigned HXW  = (HW > HANDLE_W) ? HW : HANDLE_W;

  state_e                state_q, state_d;
  logic                  func_q, func_d;
  logic [HW-1:0]         h_q, h_d;
  logic                  was_q, was_d;
  logic                  evv_q, evv_d;
  logic [HW-1:0]         evh_q, evh_d;
  logic [HW-1:0]         newest_q, newest_d;
  logic [HW-1:0]         oldest_q, oldest_d;
  logic [CW-1:0]         count_q, count_d;
  logic [MAX_OPEN_W-1:0] max_open_q;
  logic                  out_vld_q, out_vld_d;
  res_t                  res_q, res_d;

  logic [CMPW-1:0] cnt_ext, max_ext;
  logic [HXW-1:0]  evh_ext;
  logic            evict;
  logic            single;

  assign cnt_ext = CMPW'(count_q);
  assign max_ext = CMPW'(max_open_q);
  assign evh_ext = HXW'(evh_q);
  assign evict   = (cnt_ext >= max_ext) && (count_q != '0);
  assign single  = (count_q <= CW'(1));

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    h_d       = h_q;
    was_d     = was_q;
    evv_d     = evv_q;
    evh_d     = evh_q;
    newest_d  = newest_q;
    oldest_d  = oldest_q;
    count_d   = count_q;
    out_vld_d = out_vld_q && !out_ready_i;
    res_d     = res_q;
    mctl_o    = '0;
    raddr_o   = h_q;
    a_waddr_o = '0;
    a_wnwr_o  = '0;
    b_waddr_o = '0;
    b_wdata_o = '0;
    in_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = !busy_i;
        if (in_valid_i && !busy_i) begin
          func_d    = in_func_i;
          h_d       = in_idx_i;
          evv_d     = 1'b0;
          evh_d     = '0;
          mctl_o.rd = 1'b1;
          raddr_o   = in_idx_i;
          state_d   = ST_LOOK;
        end
      end

      // entry of the requested handle is on the read port
      ST_LOOK: begin
        was_d = rd_inl_i;
        if (rd_inl_i) begin
          // unlink the handle
          if (single) begin
            newest_d = '0;
            oldest_d = '0;
          end else begin
            if (h_q == newest_q) begin
              newest_d = rd_old_i;
            end else begin
              mctl_o.b_we = 1'b1;
              b_waddr_o   = rd_nwr_i;
              b_wdata_o   = rd_old_i;
            end
            if (h_q == oldest_q) begin
              oldest_d = rd_nwr_i;
            end else begin
              mctl_o.a_we  = 1'b1;
              mctl_o.a_inl = 1'b1;
              a_waddr_o    = rd_old_i;
              a_wnwr_o     = rd_nwr_i;
            end
          end
          count_d = count_q - 1'b1;
          state_d = (func_q == FUNC_CLOSE) ? ST_MARK : ST_PUSH;
        end else if (func_q == FUNC_CLOSE) begin
          state_d = ST_FIN;
        end else if (evict) begin
          mctl_o.rd = 1'b1;
          raddr_o   = oldest_q;
          evv_d     = 1'b1;
          evh_d     = oldest_q;
          state_d   = ST_VICT;
        end else begin
          state_d = ST_PUSH;
        end
      end

      // victim's newer link is on the read port; its older link never matters
      ST_VICT: begin
        if (single) begin
          newest_d = '0;
          oldest_d = '0;
        end else begin
          oldest_d = rd_nwr_i;
        end
        mctl_o.a_we = 1'b1;
        a_waddr_o   = oldest_q;
        count_d     = count_q - 1'b1;
        state_d     = ST_PUSH;
      end

      ST_PUSH: begin
        if (count_q == '0) begin
          oldest_d = h_q;
        end else begin
          mctl_o.a_we  = 1'b1;
          mctl_o.a_inl = 1'b1;
          a_waddr_o    = newest_q;
          a_wnwr_o     = h_q;
          mctl_o.b_we  = 1'b1;
          b_waddr_o    = h_q;
          b_wdata_o    = newest_q;
        end
        newest_d = h_q;
        count_d  = count_q + 1'b1;
        // a re-used handle keeps its listed flag
        state_d  = was_q ? ST_FIN : ST_MARK;
      end

      ST_MARK: begin
        mctl_o.a_we  = 1'b1;
        mctl_o.a_inl = (func_q == FUNC_USE);
        a_waddr_o    = h_q;
        state_d      = ST_FIN;
      end

      ST_FIN: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d            = 1'b1;
          res_d.evicted_valid  = evv_q;
          res_d.evicted_handle = evh_ext[HANDLE_W-1:0];
          res_d.was_open       = was_q;
          res_d.open_count     = cnt_ext[COUNT_W-1:0];
          state_d              = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      newest_q   <= '0;
      oldest_q   <= '0;
      count_q    <= '0;
      max_open_q <= MAX_OPEN_RESET;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      newest_q   <= newest_d;
      oldest_q   <= oldest_d;
      count_q    <= count_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        max_open_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    h_q    <= h_d;
    was_q  <= was_d;
    evv_q  <= evv_d;
    evh_q  <= evh_d;
    res_q  <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = res_q;

  `LRT_ASSERT_NEXT(a_accept_to_look, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_LOOK, "accepted beat did not start a lookup")
  `LRT_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(HANDLES), "open count above handle count")
  `LRT_ASSERT_NOW(a_evict_only_miss, clk_i, rst_ni, state_q == ST_FIN && evv_q, !was_q && func_q == FUNC_USE, "eviction on a hit or a close")
  `LRT_ASSERT_NOW(a_use_leaves_open, clk_i, rst_ni, state_q == ST_FIN && func_q == FUNC_USE, count_q != '0, "list empty after a use")

endmodule

// ===== rtl/lru_open_handle_tracker.sv =====
// LRU open-handle tracker, top level.
// Request channel (s_axis_*): tuser[0] is the function (0 use, 1 close),
// tdata[5:0] the handle; handles at or above HANDLES wrap modulo HANDLES.
// Result channel (m_axis_*): one beat per request, in request order.
// Configuration: cfg_we_i writes cfg_wdata_i into the cap on open handles;
// write it only while no request is in flight.
// The accepting idle cycle reads the handle's entry; the result beat is then
// registered in the finish state. A close of a handle not open goes straight
// to finish, other closes unlink and mark the handle, re-used handles are
// unlinked and pushed, a new handle is pushed and marked, and an eviction
// first reads the victim. The steps are set by the registered read port and
// the single write port of each link array: an unlink and a push each write
// once or twice, and an eviction needs a second read for the victim's neighbour.
// One request is in flight at a time; the next is accepted once the current
// result is registered, even if the receiver has not yet taken it.
// If the receiver stalls with a result still held, the next request completes
// up to its last step and waits there until the held beat is taken.
// After reset the list is empty and the cap is 32; the listed flags are
// swept clear entry by entry, during which s_axis_tready stays low.
module lru_open_handle_tracker import lrt_pkg::*; #(
  parameter int unsigned HANDLES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [5:0] handle, [7:6] zero
  input  logic [0:0]            s_axis_tuser,  // [0] func
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,  // [0] evicted_valid, [6:1] evicted_handle,
                                               // [7] was_open, [14:8] open_count, [15] zero
  input  logic                  cfg_we_i,
  input  logic [MAX_OPEN_W-1:0] cfg_wdata_i
);

  localparam int unsigned HW    = (HANDLES > 1) ? $clog2(HANDLES) : 1;
  localparam int unsigned NCODE = 2 ** HANDLE_W;

  // handle code to index, modulo HANDLES, as a constant table
  logic [HW-1:0] idx_tab [NCODE];
  for (genvar gi = 0; gi < NCODE; gi++) begin : g_idx
    assign idx_tab[gi] = HW'(gi % HANDLES);
  end

  logic [HW-1:0] in_idx;
  assign in_idx = idx_tab[s_axis_tdata[HANDLE_W-1:0]];

  mem_ctl_t      mctl;
  logic [HW-1:0] raddr, a_waddr, a_wnwr, b_waddr, b_wdata;
  logic          rd_inl;
  logic [HW-1:0] rd_nwr, rd_old;
  logic          mem_busy;
  res_t          res;

  lrt_ctrl #(
    .HANDLES (HANDLES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_func_i   (s_axis_tuser[0]),
    .in_idx_i    (in_idx),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .mctl_o      (mctl),
    .raddr_o     (raddr),
    .a_waddr_o   (a_waddr),
    .a_wnwr_o    (a_wnwr),
    .b_waddr_o   (b_waddr),
    .b_wdata_o   (b_wdata),
    .rd_inl_i    (rd_inl),
    .rd_nwr_i    (rd_nwr),
    .rd_old_i    (rd_old),
    .busy_i      (mem_busy)
  );

  lrt_link_mem #(
    .HANDLES (HANDLES)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mctl),
    .raddr_i   (raddr),
    .a_waddr_i (a_waddr),
    .a_wnwr_i  (a_wnwr),
    .b_waddr_i (b_waddr),
    .b_wdata_i (b_wdata),
    .rd_inl_o  (rd_inl),
    .rd_nwr_o  (rd_nwr),
    .rd_old_o  (rd_old),
    .busy_o    (mem_busy)
  );

  assign m_axis_tdata = {1'b0, res};

endmodule
